### rtl/core/rbmc_pkg.sv
// Shared types and constants for the 16-bit byte-memory CPU core.
// No dependencies; used by the front end, back end and top level of the core.
package rbmc_pkg;

    localparam int MEM_BYTES = 65536;
    localparam int REG_COUNT = 8;

    localparam logic [15:0] DSP_TOP    = 16'hFFF0;
    localparam logic [15:0] DSP_BOTTOM = 16'hFBEF;
    localparam logic [15:0] CSP_TOP    = 16'hFBF0;
    localparam logic [15:0] CSP_BOTTOM = 16'hF7EF;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EXEC = 1'b1;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_STACK_OVER = 3'd1;
    localparam logic [2:0] ERR_STACK_UNDR = 3'd2;
    localparam logic [2:0] ERR_CALL_OVER  = 3'd3;
    localparam logic [2:0] ERR_CALL_UNDR  = 3'd4;
    localparam logic [2:0] ERR_DIV_ZERO   = 3'd5;

    typedef enum logic [4:0] {
        OP_NOP  = 5'd0,  OP_LDI  = 5'd1,  OP_LOD  = 5'd2,  OP_STR  = 5'd3,
        OP_CALL = 5'd4,  OP_RET  = 5'd5,  OP_PUSH = 5'd6,  OP_POP  = 5'd7,
        OP_MOV  = 5'd8,  OP_ADD  = 5'd9,  OP_SUB  = 5'd10, OP_MUL  = 5'd11,
        OP_DIV  = 5'd12, OP_MOD  = 5'd13, OP_INC  = 5'd14, OP_DEC  = 5'd15,
        OP_SHL  = 5'd16, OP_SHR  = 5'd17, OP_AND  = 5'd18, OP_NAND = 5'd19,
        OP_OR   = 5'd20, OP_NOR  = 5'd21, OP_XOR  = 5'd22, OP_HALT = 5'd31
    } op_t;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_F0, ST_F1, ST_F2, ST_EXEC,
        ST_LOD, ST_RET, ST_POP, ST_DIV
    } state_t;

    typedef struct packed {
        logic        action;
        logic [15:0] load_address;
        logic [7:0]  load_byte;
    } item_t;

    typedef struct packed {
        logic [15:0] program_counter;
        logic [2:0]  error_code;
        logic        halted;
        logic        reg_written;
        logic [2:0]  reg_index;
        logic [15:0] reg_value;
        logic        mem_written;
        logic [15:0] mem_address;
        logic [7:0]  mem_byte;
    } result_t;

endpackage

### rtl/core/rbmc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rbmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/core/rbmc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
module rbmc_div #(
    parameter int W = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quot,
    output logic [W-1:0] rem
);

    localparam int CW = $clog2(W);
    localparam logic [CW-1:0] LAST = CW'(W - 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  q_reg;
    logic [W-1:0]  r_reg;
    logic [W-1:0]  dvs_reg;
    logic [W+1:0]  diff;
    logic          ge;

    assign diff = {1'b0, r_reg, q_reg[W-1]} - {2'b00, dvs_reg};
    assign ge   = !diff[W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == LAST);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            r_reg   <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[W-2:0], ge};
            r_reg <= ge ? diff[W-1:0] : {r_reg[W-2:0], q_reg[W-1]};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;

endmodule

### rtl/core/rbmc_front.sv
// Front end: two-entry input queue that takes transactions and hands them on.
// Depends on rbmc_pkg.
module rbmc_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  rbmc_pkg::item_t in_item,
    output logic           q_valid,
    output rbmc_pkg::item_t q_item,
    input  logic           q_pop
);

    rbmc_pkg::item_t slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       do_push;
    logic       do_pop;

    assign full    = cnt_reg[1];
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = q_pop && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

### rtl/core/rbmc_back.sv
// Back end: fetch/execute sequencer, byte memory, register file, result register.
// Depends on rbmc_pkg, rbmc_ram and rbmc_div.
module rbmc_back #(
    parameter int MEM_BYTES = rbmc_pkg::MEM_BYTES,
    parameter int REG_COUNT = rbmc_pkg::REG_COUNT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  rbmc_pkg::item_t   q_item,
    output logic              q_pop,
    output logic              res_valid,
    output rbmc_pkg::result_t res,
    input  logic              res_pop
);

    localparam int AW = $clog2(MEM_BYTES);
    localparam int RW = $clog2(REG_COUNT);

    rbmc_pkg::state_t  state_reg, state_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [15:0]       pc_reg, pc_next;
    logic [15:0]       sp_reg, sp_next;
    logic [15:0]       csp_reg, csp_next;
    logic [2:0]        err_reg, err_next;
    logic              halt_reg, halt_next;
    logic [7:0]        b0_reg, b0_next, b1_reg, b1_next, b2_reg, b2_next;
    logic [15:0]       x_reg, x_next, y_reg, y_next;
    logic              out_valid_reg, out_valid_next;
    rbmc_pkg::result_t out_reg, out_next;

    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata, mem_rdata;
    logic          rf_we;
    logic [RW-1:0] rf_waddr, rf_raddr;
    logic [15:0]   rf_wdata, rf_rdata;
    logic          div_start, div_done;
    logic [15:0]   div_q, div_r;

    logic          fin;
    logic          w_reg;
    logic [2:0]    w_idx;
    logic [15:0]   w_val;
    logic          w_mem;
    logic [15:0]   w_addr;
    logic [7:0]    w_byte;

    rbmc_pkg::op_t op;
    logic [2:0]    f_d, f_a, f_c;
    logic [3:0]    f_s;
    logic [15:0]   imm;
    logic [31:0]   prod;
    logic [15:0]   pc1, pc2, pc3;

    assign op   = rbmc_pkg::op_t'(b0_reg[7:3]);
    assign f_d  = b0_reg[2:0];
    assign f_a  = b1_reg[7:5];
    assign f_c  = b1_reg[4:2];
    assign f_s  = b1_reg[4:1];
    assign imm  = {b1_reg, b2_reg};
    assign prod = x_reg * y_reg;
    assign pc1  = pc_reg + 16'd1;
    assign pc2  = pc_reg + 16'd2;
    assign pc3  = pc_reg + 16'd3;

    rbmc_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    rbmc_ram #(.WIDTH(16), .DEPTH(REG_COUNT)) u_rf (
        .clk     (clk),
        .wr_en   (rf_we),
        .wr_addr (rf_waddr),
        .wr_data (rf_wdata),
        .rd_addr (rf_raddr),
        .rd_data (rf_rdata)
    );

    rbmc_div #(.W(16)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (x_reg),
        .divisor  (y_reg),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rbmc_pkg::ST_CLEAR;
            clr_reg       <= '0;
            pc_reg        <= 16'd0;
            sp_reg        <= rbmc_pkg::DSP_TOP;
            csp_reg       <= rbmc_pkg::CSP_TOP;
            err_reg       <= rbmc_pkg::ERR_NONE;
            halt_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pc_reg        <= pc_next;
            sp_reg        <= sp_next;
            csp_reg       <= csp_next;
            err_reg       <= err_next;
            halt_reg      <= halt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b0_reg  <= b0_next;
        b1_reg  <= b1_next;
        b2_reg  <= b2_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        out_reg <= out_next;
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        pc_next    = pc_reg;
        sp_next    = sp_reg;
        csp_next   = csp_reg;
        err_next   = err_reg;
        halt_next  = halt_reg;
        b0_next    = b0_reg;
        b1_next    = b1_reg;
        b2_next    = b2_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = 8'd0;
        mem_raddr  = pc_reg[AW-1:0];
        rf_raddr   = '0;
        div_start  = 1'b0;
        fin        = 1'b0;
        w_reg      = 1'b0;
        w_idx      = 3'd0;
        w_val      = 16'd0;
        w_mem      = 1'b0;
        w_addr     = 16'd0;
        w_byte     = 8'd0;

        unique case (state_reg)
            rbmc_pkg::ST_CLEAR:
            begin
                // zero the byte memory and register file, one entry a cycle
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == {AW{1'b1}})
                begin
                    state_next = rbmc_pkg::ST_IDLE;
                end
            end
            rbmc_pkg::ST_IDLE:
            begin
                if (q_valid && !out_valid_reg)
                begin
                    q_pop = 1'b1;
                    if (halt_reg)
                    begin
                        fin = 1'b1;
                    end
                    else if (q_item.action == rbmc_pkg::ACT_LOAD)
                    begin
                        fin    = 1'b1;
                        w_mem  = 1'b1;
                        w_addr = q_item.load_address;
                        w_byte = q_item.load_byte;
                    end
                    else
                    begin
                        state_next = rbmc_pkg::ST_F0;
                    end
                end
            end
            rbmc_pkg::ST_F0:
            begin
                b0_next    = mem_rdata;
                mem_raddr  = pc1[AW-1:0];
                rf_raddr   = mem_rdata[RW-1:0];
                state_next = rbmc_pkg::ST_F1;
            end
            rbmc_pkg::ST_F1:
            begin
                b1_next    = mem_rdata;
                x_next     = rf_rdata;
                mem_raddr  = pc2[AW-1:0];
                rf_raddr   = mem_rdata[5 +: RW];
                state_next = rbmc_pkg::ST_F2;
            end
            rbmc_pkg::ST_F2:
            begin
                b2_next    = mem_rdata;
                y_next     = rf_rdata;
                state_next = rbmc_pkg::ST_EXEC;
            end
            rbmc_pkg::ST_EXEC:
            begin
                state_next = rbmc_pkg::ST_IDLE;
                fin        = 1'b1;
                case (op)
                    rbmc_pkg::OP_NOP: pc_next = pc1;
                    rbmc_pkg::OP_LDI:
                    begin
                        pc_next = pc3;
                        w_reg   = 1'b1;
                        w_idx   = f_d;
                        w_val   = imm;
                    end
                    rbmc_pkg::OP_LOD:
                    begin
                        fin        = 1'b0;
                        mem_raddr  = y_reg[AW-1:0];
                        state_next = rbmc_pkg::ST_LOD;
                    end
                    rbmc_pkg::OP_STR:
                    begin
                        pc_next = pc2;
                        w_mem   = 1'b1;
                        w_addr  = y_reg;
                        w_byte  = x_reg[7:0];
                    end
                    rbmc_pkg::OP_CALL:
                    begin
                        if (csp_reg == rbmc_pkg::CSP_BOTTOM)
                        begin
                            pc_next  = pc3;
                            err_next = rbmc_pkg::ERR_CALL_OVER;
                        end
                        else
                        begin
                            csp_next = csp_reg - 16'd1;
                            pc_next  = imm;
                            w_mem    = 1'b1;
                            w_addr   = csp_reg - 16'd1;
                            w_byte   = pc3[7:0];
                        end
                    end
                    rbmc_pkg::OP_RET:
                    begin
                        if (csp_reg == rbmc_pkg::CSP_TOP)
                        begin
                            pc_next  = pc1;
                            err_next = rbmc_pkg::ERR_CALL_UNDR;
                        end
                        else
                        begin
                            fin        = 1'b0;
                            mem_raddr  = csp_reg[AW-1:0];
                            state_next = rbmc_pkg::ST_RET;
                        end
                    end
                    rbmc_pkg::OP_PUSH:
                    begin
                        pc_next = pc1;
                        if (sp_reg == rbmc_pkg::DSP_BOTTOM)
                        begin
                            err_next = rbmc_pkg::ERR_STACK_OVER;
                        end
                        else
                        begin
                            sp_next = sp_reg - 16'd1;
                            w_mem   = 1'b1;
                            w_addr  = sp_reg - 16'd1;
                            w_byte  = x_reg[7:0];
                        end
                    end
                    rbmc_pkg::OP_POP:
                    begin
                        if (sp_reg == rbmc_pkg::DSP_TOP)
                        begin
                            pc_next  = pc1;
                            err_next = rbmc_pkg::ERR_STACK_UNDR;
                        end
                        else
                        begin
                            fin        = 1'b0;
                            mem_raddr  = sp_reg[AW-1:0];
                            state_next = rbmc_pkg::ST_POP;
                        end
                    end
                    rbmc_pkg::OP_DIV, rbmc_pkg::OP_MOD:
                    begin
                        if (y_reg == 16'd0)
                        begin
                            pc_next  = pc2;
                            err_next = rbmc_pkg::ERR_DIV_ZERO;
                        end
                        else
                        begin
                            fin        = 1'b0;
                            div_start  = 1'b1;
                            state_next = rbmc_pkg::ST_DIV;
                        end
                    end
                    rbmc_pkg::OP_HALT: halt_next = 1'b1;
                    rbmc_pkg::OP_MOV, rbmc_pkg::OP_INC, rbmc_pkg::OP_DEC,
                    rbmc_pkg::OP_SHL, rbmc_pkg::OP_SHR:
                    begin
                        pc_next = pc2;
                        w_reg   = 1'b1;
                        w_idx   = f_a;
                        unique case (op)
                            rbmc_pkg::OP_INC: w_val = x_reg + 16'd1;
                            rbmc_pkg::OP_DEC: w_val = x_reg - 16'd1;
                            rbmc_pkg::OP_SHL: w_val = x_reg << f_s;
                            rbmc_pkg::OP_SHR: w_val = x_reg >> f_s;
                            default:          w_val = x_reg;
                        endcase
                    end
                    rbmc_pkg::OP_ADD, rbmc_pkg::OP_SUB, rbmc_pkg::OP_MUL,
                    rbmc_pkg::OP_AND, rbmc_pkg::OP_NAND, rbmc_pkg::OP_OR,
                    rbmc_pkg::OP_NOR, rbmc_pkg::OP_XOR:
                    begin
                        pc_next = pc2;
                        w_reg   = 1'b1;
                        w_idx   = f_c;
                        unique case (op)
                            rbmc_pkg::OP_ADD:  w_val = x_reg + y_reg;
                            rbmc_pkg::OP_SUB:  w_val = x_reg - y_reg;
                            rbmc_pkg::OP_MUL:  w_val = prod[15:0];
                            rbmc_pkg::OP_AND:  w_val = x_reg & y_reg;
                            rbmc_pkg::OP_NAND: w_val = ~(x_reg & y_reg);
                            rbmc_pkg::OP_OR:   w_val = x_reg | y_reg;
                            rbmc_pkg::OP_NOR:  w_val = ~(x_reg | y_reg);
                            default:           w_val = x_reg ^ y_reg;
                        endcase
                    end
                    // unassigned opcodes leave everything alone
                    default: pc_next = pc_reg;
                endcase
            end
            rbmc_pkg::ST_LOD:
            begin
                fin        = 1'b1;
                pc_next    = pc2;
                w_reg      = 1'b1;
                w_idx      = f_d;
                w_val      = {8'd0, mem_rdata};
                state_next = rbmc_pkg::ST_IDLE;
            end
            rbmc_pkg::ST_RET:
            begin
                fin        = 1'b1;
                csp_next   = csp_reg + 16'd1;
                pc_next    = {8'd0, mem_rdata};
                state_next = rbmc_pkg::ST_IDLE;
            end
            rbmc_pkg::ST_POP:
            begin
                fin        = 1'b1;
                pc_next    = pc1;
                sp_next    = sp_reg + 16'd1;
                w_reg      = 1'b1;
                w_idx      = f_d;
                w_val      = {8'd0, mem_rdata};
                state_next = rbmc_pkg::ST_IDLE;
            end
            rbmc_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    fin        = 1'b1;
                    pc_next    = pc2;
                    w_reg      = 1'b1;
                    w_idx      = f_c;
                    w_val      = (op == rbmc_pkg::OP_DIV) ? div_q : div_r;
                    state_next = rbmc_pkg::ST_IDLE;
                end
            end
            default: state_next = rbmc_pkg::ST_IDLE;
        endcase

        if (w_mem)
        begin
            mem_we    = 1'b1;
            mem_waddr = w_addr[AW-1:0];
            mem_wdata = w_byte;
        end
    end

    // register file write: cleared during the memory sweep, else the step's write
    always_comb
    begin
        if (state_reg == rbmc_pkg::ST_CLEAR)
        begin
            rf_we    = 1'b1;
            rf_waddr = clr_reg[RW-1:0];
            rf_wdata = 16'd0;
        end
        else
        begin
            rf_we    = w_reg;
            rf_waddr = w_idx[RW-1:0];
            rf_wdata = w_val;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !res_pop;
        out_next       = out_reg;
        if (fin)
        begin
            out_valid_next           = 1'b1;
            out_next.program_counter = pc_next;
            out_next.error_code      = err_next;
            out_next.halted          = halt_next;
            out_next.reg_written     = w_reg;
            out_next.reg_index       = w_idx;
            out_next.reg_value       = w_val;
            out_next.mem_written     = w_mem;
            out_next.mem_address     = w_addr;
            out_next.mem_byte        = w_byte;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

### rtl/core/risc16_byte_memory_cpu_core_unit.sv
// Top level of the 16-bit byte-memory CPU core: input queue plus execute engine.
// Depends on rbmc_pkg, rbmc_front and rbmc_back.
//
//   channel   handshake        payload
//   input     push / full      action, load_address, load_byte
//   result    empty / pop      program_counter .. mem_byte
//
// From taking an item off the queue to loading the result register, the
// engine finishes a memory load in the idle state; an instruction is fetched
// as three bytes through the byte RAM's single read port (F0, F1, F2), then
// executed; LOD, RET and POP add a RAM read, DIV and MOD a divider wait.
// After reset a clearing pass zeroes the 65536-byte memory, one byte a cycle;
// items are queued (two deep) but not executed until it ends.
// The engine waits while a result is not yet popped and takes the next item
// in the cycle after the pop; the queue keeps taking input.
module risc16_byte_memory_cpu_core_unit #(
    parameter int MEM_BYTES = rbmc_pkg::MEM_BYTES,
    parameter int REG_COUNT = rbmc_pkg::REG_COUNT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        action,
    input  logic [15:0] load_address,
    input  logic [7:0]  load_byte,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] program_counter,
    output logic [2:0]  error_code,
    output logic        halted,
    output logic        reg_written,
    output logic [2:0]  reg_index,
    output logic [15:0] reg_value,
    output logic        mem_written,
    output logic [15:0] mem_address,
    output logic [7:0]  mem_byte
);

    rbmc_pkg::item_t   in_item;
    rbmc_pkg::item_t   q_item;
    rbmc_pkg::result_t res;
    logic              q_valid;
    logic              q_pop;
    logic              res_valid;

    assign in_item.action       = action;
    assign in_item.load_address = load_address;
    assign in_item.load_byte    = load_byte;

    rbmc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .in_item (in_item),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    rbmc_back #(
        .MEM_BYTES (MEM_BYTES),
        .REG_COUNT (REG_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res       (res),
        .res_pop   (pop)
    );

    assign empty           = !res_valid;
    assign program_counter = res.program_counter;
    assign error_code      = res.error_code;
    assign halted          = res.halted;
    assign reg_written     = res.reg_written;
    assign reg_index       = res.reg_index;
    assign reg_value       = res.reg_value;
    assign mem_written     = res.mem_written;
    assign mem_address     = res.mem_address;
    assign mem_byte        = res.mem_byte;

endmodule

### rtl/core/rbmc_checker.sv
// Port-level checks for the CPU core, bound to the top level.
// Depends on risc16_byte_memory_cpu_core_unit.
module rbmc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [15:0] program_counter,
    input logic [2:0]  error_code,
    input logic        halted,
    input logic        reg_written,
    input logic [2:0]  reg_index,
    input logic [15:0] reg_value,
    input logic        mem_written,
    input logic [15:0] mem_address,
    input logic [7:0]  mem_byte
);

    // a halted core never reports a write
    a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && halted) |-> (!reg_written && !mem_written))
        else $error("write reported while halted");

    // a transaction that is not popped stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(program_counter)
                              && $stable(error_code) && $stable(mem_address)))
        else $error("pending result changed");

    a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (error_code <= 3'd5))
        else $error("error code out of range");

    a_no_reg_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !reg_written) |-> (reg_index == 3'd0 && reg_value == 16'd0))
        else $error("register fields set without a write");

    a_no_mem_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !mem_written) |-> (mem_address == 16'd0 && mem_byte == 8'd0))
        else $error("memory fields set without a write");

endmodule

bind risc16_byte_memory_cpu_core_unit rbmc_checker u_rbmc_checker (.*);
